@@ rtl/core/settings_frame_parser_top_macros.svh @@
// Assertion helpers shared by the frame parser RTL.
// Each macro checks a property on the rising clock edge, muted while reset is held.
`ifndef SETTINGS_FRAME_PARSER_TOP_MACROS_SVH
`define SETTINGS_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication
`define SFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Next-cycle implication
`define SFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

@@ rtl/core/sfp_pkg.sv @@
`default_nettype none

package sfp_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LEN   = 12;
  localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned BYTE_W      = 7;
  localparam int unsigned VAL_W       = 14;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 80;
  localparam int unsigned KIND_W      = 2;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  // Byte clamp and command codes
  localparam logic [IN_DATA_W-1:0] BYTE_MAX     = 8'h63;
  localparam logic [BYTE_W-1:0]    CODE_WIDTHS  = 7'h0a;
  localparam logic [BYTE_W-1:0]    CODE_PERIODS = 7'h14;
  localparam logic [BYTE_W-1:0]    CODE_CHARGE  = 7'h1e;

  // Value limits
  localparam logic [VAL_W-1:0] CHARGE_MAX = 14'd130;
  localparam logic [VAL_W-1:0] MIN_WIDTH  = 14'd5;
  localparam logic [VAL_W-1:0] MIN_CHARGE = 14'd3;

  // Frame kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 2'd0,
    KIND_WIDTHS  = 2'd1,
    KIND_PERIODS = 2'd2,
    KIND_CHARGE  = 2'd3
  } kind_t;

  // Completed frame: body[0] is the first byte, last is the twelfth
  typedef struct packed {
    logic [STORE_DEPTH-1:0][BYTE_W-1:0] body;
    logic [BYTE_W-1:0]                  last;
  } frame_t;

  // Decoded result
  typedef struct packed {
    kind_t                 kind;
    logic [4:0][VAL_W-1:0] vals;
    logic [BYTE_W-1:0]     ack;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/sfp_collect.sv @@
`default_nettype none

module sfp_collect
  import sfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 frame_take,
  output frame_t                    frame,
  output logic                      frame_vld
);

  `include "settings_frame_parser_top_macros.svh"

  logic [STORE_DEPTH-1:0][BYTE_W-1:0] store_r;
  logic [POS_W-1:0]                   pos_r, pos_nxt;
  logic                               frame_vld_r, frame_vld_nxt;
  frame_t                             frame_r;
  logic [BYTE_W-1:0]                  byte_c;
  logic                               accept, at_last;

  // Handshake: free when the frame slot is empty or drains this cycle
  assign in_tready = !frame_vld_r || frame_take;
  assign accept    = in_tvalid && in_tready;
  assign at_last   = (pos_r >= LAST_POS);

  // Clamp to 99
  assign byte_c = (in_tdata > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] : in_tdata[BYTE_W-1:0];

  // Position and frame slot control
  always_comb begin
    pos_nxt       = pos_r;
    frame_vld_nxt = frame_vld_r;
    if (frame_take) begin
      frame_vld_nxt = 1'b0;
    end
    if (accept) begin
      if (at_last) begin
        pos_nxt       = '0;
        frame_vld_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      frame_vld_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      frame_vld_r <= frame_vld_nxt;
    end
  end

  // Byte store and frame snapshot
  always_ff @(posedge clk) begin
    if (accept) begin
      if (at_last) begin
        frame_r.body <= store_r;
        frame_r.last <= byte_c;
      end else begin
        store_r[pos_r] <= byte_c;
      end
    end
  end

  assign frame     = frame_r;
  assign frame_vld = frame_vld_r;

  `SFP_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, pos_r <= LAST_POS)
  `SFP_ASSERT_NXT(a_last_wraps, clk, rst_n, accept && at_last,
                  frame_vld_r && pos_r == '0)
  `SFP_ASSERT_NXT(a_mid_steps, clk, rst_n, accept && !at_last,
                  pos_r == $past(pos_r) + POS_W'(1) && frame_vld_r == $past(frame_vld_nxt))

endmodule

`default_nettype wire

@@ rtl/core/sfp_decode.sv @@
`default_nettype none

module sfp_decode
  import sfp_pkg::*;
(
  input  wire frame_t frame,
  output result_t     result
);

  logic [4:0][VAL_W-1:0] pair;
  logic [VAL_W-1:0]      charge;
  logic                  match;

  // Two-digit pairs: high*100 + low, 100 = 64 + 32 + 4
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      pair[i] = (VAL_W'(frame.body[1 + 2*i]) << 6) + (VAL_W'(frame.body[1 + 2*i]) << 5)
              + (VAL_W'(frame.body[1 + 2*i]) << 2) + VAL_W'(frame.body[2 + 2*i]);
    end
  end

  // Charge time saturates at 130
  assign charge = (pair[0] >= CHARGE_MAX) ? CHARGE_MAX : pair[0];
  assign match  = (frame.body[0] == frame.last);

  // Kind select and value defaults
  always_comb begin
    result.kind = KIND_NONE;
    result.vals = '0;
    result.ack  = '0;
    if (match && (frame.last == CODE_WIDTHS || frame.last == CODE_PERIODS)) begin
      result.kind = (frame.last == CODE_WIDTHS) ? KIND_WIDTHS : KIND_PERIODS;
      for (int i = 0; i < 5; i++) begin
        result.vals[i] = (pair[i] == '0) ? MIN_WIDTH : pair[i];
      end
      result.ack = frame.last;
    end else if (match && frame.last == CODE_CHARGE) begin
      result.kind    = KIND_CHARGE;
      result.vals[0] = (charge == '0) ? MIN_CHARGE : charge;
      result.vals[1] = (pair[1] == '0) ? MIN_CHARGE : pair[1];
      result.vals[2] = VAL_W'(frame.body[5]);
      result.ack     = frame.last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/settings_frame_parser_top.sv @@
// Path: the twelfth byte of a frame is captured in the frame snapshot register, then its result in the output register.
// Throughput: one input beat per cycle while in_tready is high; a frame of twelve bytes yields one result beat.
// Rate is set by a frame snapshot register and an output register with pass-through ready.
// Reset: synchronous, active low; clears byte position and both valid flags, store is not cleared.
`default_nettype none

module settings_frame_parser_top
  import sfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [13:0] value_one, [27:14] value_two,
                                                 // [41:28] value_three, [55:42] value_four,
                                                 // [69:56] value_five, [76:70] ack_byte, zero pad
  output logic [KIND_W-1:0]          out_tuser   // [1:0] frame_kind
);

  `include "settings_frame_parser_top_macros.svh"

  frame_t  frame;
  logic    frame_vld;
  result_t result;
  result_t res_r;
  logic    out_vld_r, out_vld_nxt;
  logic    out_en;

  // Output register loads when empty or being drained
  assign out_en = !out_vld_r || out_tready;

  sfp_collect u_collect (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .frame_take (out_en),
    .frame      (frame),
    .frame_vld  (frame_vld)
  );

  sfp_decode u_decode (
    .frame  (frame),
    .result (result)
  );

  assign out_vld_nxt = out_en ? frame_vld : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && frame_vld) begin
      res_r <= result;
    end
  end

  // Result beat packing
  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {3'b000, res_r.ack, res_r.vals[4], res_r.vals[3], res_r.vals[2],
                       res_r.vals[1], res_r.vals[0]};

  `SFP_ASSERT_NXT(a_frame_lands, clk, rst_n, frame_vld && out_en, out_vld_r)
  `SFP_ASSERT_IMP(a_none_no_ack, clk, rst_n, out_vld_r && res_r.kind == KIND_NONE,
                  res_r.ack == '0 && res_r.vals == '0)

endmodule

`default_nettype wire

@@ test/tb_settings_frame_parser_top.sv @@
`timescale 1ns / 1ps

module tb_settings_frame_parser_top;
  import sfp_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int DIR_ROWS     = 4;
  localparam int RANDOM_BYTES = 1100;
  localparam int IDLE_PCT     = 34;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_MAX   = 10;

  // Directed frames, byte 0 first
  localparam logic [7:0] DIR_BYTES [DIR_ROWS*FRAME_LEN] = '{
    8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10,
    8'd30, 8'd255, 8'd99, 8'd0, 8'd0, 8'd200, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd30,
    8'd10, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd20,
    8'd20, 8'd99, 8'd99, 8'd0, 8'd1, 8'd12, 8'd34, 8'd100, 8'd5, 8'd0, 8'd0, 8'd20
  };
  // Rows whose result is typed in below; the rest go through the predictor
  localparam bit DIR_TYPED [DIR_ROWS] = '{1'b1, 1'b1, 1'b1, 1'b0};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;

  settings_frame_parser_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Predictor state: bytes of the frame in progress and the next position
  logic [BYTE_W-1:0] frame_bytes [STORE_DEPTH];
  logic [POS_W-1:0]  frame_pos = '0;

  result_t settings_due [$];
  result_t dir_exp [DIR_ROWS];

  int  fail_count  = 0;
  int  frames_done = 0;
  int  bytes_sent  = 0;
  int  holds_done  = 0;
  int  stall_count = 0;
  int  kind_seen [4] = '{0, 0, 0, 0};
  bit  calm     = 1'b0;
  bit  hold_req = 1'b0;

  // Clock
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic result_t mk_result(kind_t k, int unsigned v1, int unsigned v2,
                                        int unsigned v3, int unsigned v4, int unsigned v5,
                                        int unsigned a);
    result_t r;
    r.kind    = k;
    r.vals[0] = VAL_W'(v1);
    r.vals[1] = VAL_W'(v2);
    r.vals[2] = VAL_W'(v3);
    r.vals[3] = VAL_W'(v4);
    r.vals[4] = VAL_W'(v5);
    r.ack     = BYTE_W'(a);
    return r;
  endfunction

  // Two stored digits as high*100+low
  function automatic logic [VAL_W-1:0] pair_at(int k);
    return VAL_W'(frame_bytes[k]) * VAL_W'(100) + VAL_W'(frame_bytes[k+1]);
  endfunction

  // Predictor: one received byte in, at most one decoded frame out
  task automatic parse_rx_byte(input logic [7:0] raw, output bit done, output result_t r);
    logic [BYTE_W-1:0] b;
    logic [VAL_W-1:0]  v;
    int                i;
    b    = (raw > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] : raw[BYTE_W-1:0];
    done = 1'b0;
    r    = '0;
    r.kind = KIND_NONE;
    if (frame_pos < LAST_POS) begin
      frame_bytes[frame_pos] = b;
      frame_pos = frame_pos + POS_W'(1);
    end else begin
      frame_pos = '0;
      done      = 1'b1;
      if (frame_bytes[0] == b && (b == CODE_WIDTHS || b == CODE_PERIODS)) begin
        r.kind = (b == CODE_WIDTHS) ? KIND_WIDTHS : KIND_PERIODS;
        for (i = 0; i < 5; i++) begin
          v = pair_at(1 + 2*i);
          r.vals[i] = (v == '0) ? MIN_WIDTH : v;
        end
        r.ack = b;
      end else if (frame_bytes[0] == b && b == CODE_CHARGE) begin
        r.kind = KIND_CHARGE;
        // charge saturates, then zero becomes the minimum
        v = pair_at(1);
        if (v >= CHARGE_MAX) v = CHARGE_MAX;
        r.vals[0] = (v == '0) ? MIN_CHARGE : v;
        v = pair_at(3);
        r.vals[1] = (v == '0) ? MIN_CHARGE : v;
        r.vals[2] = VAL_W'(frame_bytes[5]);
        r.ack = b;
      end
    end
  endtask

  // Digit-like byte, biased to zero, one, the clamp point and above it
  function automatic logic [7:0] pick_digit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15)      return 8'd0;
    else if (r < 25) return 8'd99;
    else if (r < 35) return 8'($urandom_range(255, 100));
    else if (r < 40) return 8'd1;
    else             return 8'($urandom_range(99));
  endfunction

  // Offer one byte after a random gap, return once it is accepted
  task automatic push_byte(input logic [7:0] b);
    calm = (bytes_sent >= 500 && bytes_sent < 750);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // Scoreboard: results against the oldest expectation, then new bytes into the predictor
  always @(posedge clk) begin
    bit      done;
    result_t pred;
    result_t want;
    logic    bad;
    int      i;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (settings_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result beat: kind %0d data %h", out_tuser, out_tdata);
        end else begin
          want = settings_due.pop_front();
          kind_seen[want.kind]++;
          bad = (out_tuser !== want.kind) || (out_tdata[76:70] !== want.ack) ||
                (out_tdata[OUT_DATA_W-1:77] !== '0);
          for (i = 0; i < 5; i++)
            bad = bad || (out_tdata[VAL_W*i +: VAL_W] !== want.vals[i]);
          if (bad) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("result mismatch: kind %0d/%0d ack %0d/%0d pad %b",
                       out_tuser, want.kind, out_tdata[76:70], want.ack,
                       out_tdata[OUT_DATA_W-1:77]);
              $display("  vals %0d %0d %0d %0d %0d / %0d %0d %0d %0d %0d",
                       out_tdata[13:0], out_tdata[27:14], out_tdata[41:28],
                       out_tdata[55:42], out_tdata[69:56],
                       want.vals[0], want.vals[1], want.vals[2], want.vals[3],
                       want.vals[4]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        parse_rx_byte(in_tdata, done, pred);
        if (done) begin
          if (frames_done < DIR_ROWS && DIR_TYPED[frames_done])
            settings_due.push_back(dir_exp[frames_done]);
          else
            settings_due.push_back(pred);
          frames_done++;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0]        fr [FRAME_LEN];
    logic [BYTE_W-1:0] code;
    int unsigned       sel;
    int                chunk;
    int                k;
    int                n;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    dir_exp[0] = mk_result(KIND_WIDTHS, MIN_WIDTH, MIN_WIDTH, MIN_WIDTH, MIN_WIDTH,
                           MIN_WIDTH, CODE_WIDTHS);
    dir_exp[1] = mk_result(KIND_CHARGE, CHARGE_MAX, MIN_CHARGE, 99, 0, 0, CODE_CHARGE);
    dir_exp[2] = mk_result(KIND_NONE, 0, 0, 0, 0, 0, 0);
    dir_exp[3] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames
    for (k = 0; k < DIR_ROWS * FRAME_LEN; k++)
      push_byte(DIR_BYTES[k]);

    // Random traffic: mostly well-formed frames, some near misses and loose noise
    chunk = 0;
    while (bytes_sent < DIR_ROWS * FRAME_LEN + RANDOM_BYTES) begin
      if (chunk == 20) hold_req = 1'b1;
      if (chunk == 8 || chunk == 45 || chunk == 70) begin
        // let the block drain completely before carrying on
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (settings_due.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(99);
      if (sel < 88) begin
        // realign to a frame boundary with junk first
        while (bytes_sent % FRAME_LEN != 0) push_byte(pick_digit());
        case ($urandom_range(2))
          0:       code = CODE_WIDTHS;
          1:       code = CODE_PERIODS;
          default: code = CODE_CHARGE;
        endcase
        for (k = 1; k < FRAME_LEN - 1; k++) fr[k] = pick_digit();
        fr[0]  = {1'b0, code};
        fr[11] = {1'b0, code};
        if (code == CODE_CHARGE && $urandom_range(1) == 1) begin
          // charge near its saturation point
          fr[1] = 8'($urandom_range(1));
          fr[2] = 8'($urandom_range(35, 25));
        end
        if (sel >= 70) begin
          // near miss on one end of the frame
          case ($urandom_range(4))
            0:       n = (code == CODE_WIDTHS) ? CODE_CHARGE : CODE_WIDTHS;
            1:       n = code + 1;
            2:       n = code - 1;
            3:       n = code | 8'h80;
            default: n = pick_digit();
          endcase
          if ($urandom_range(1) == 1) fr[0] = 8'(n);
          else                        fr[11] = 8'(n);
          if ($urandom_range(3) == 0) fr[0] = fr[11];
        end
        for (k = 0; k < FRAME_LEN; k++) push_byte(fr[k]);
      end else begin
        // loose bytes that shift the framing
        n = $urandom_range(FRAME_LEN - 1, 1);
        for (k = 0; k < n; k++) push_byte(8'($urandom_range(255)));
      end
      chunk++;
    end

    // Drain
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (settings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes, %0d frames: %0d widths, %0d periods, %0d charge, %0d unrecognised",
             bytes_sent, frames_done, kind_seen[KIND_WIDTHS], kind_seen[KIND_PERIODS],
             kind_seen[KIND_CHARGE], kind_seen[KIND_NONE]);
    $display("receiver hold-offs: %0d, failures: %0d", holds_done, fail_count);
    if (fail_count == 0 && settings_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sfp_pkg.sv
rtl/core/sfp_collect.sv
rtl/core/sfp_decode.sv
rtl/core/settings_frame_parser_top.sv
test/tb_settings_frame_parser_top.sv
